// ===== rtl/ght_pkg.sv =====
// Shared types, constants and codes for the generational handle table.
package ght_pkg;

    localparam int SLOTS    = 16;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int GEN_W    = 32;
    localparam int PART_W   = 16;
    localparam int HANDLE_W = GEN_W + PART_W;
    localparam int CAP_W    = 64;
    localparam int OWNER_W  = 64;

    localparam logic [GEN_W-1:0] GEN_MAX = {GEN_W{1'b1}};

    localparam logic [1:0] REQ_CREATE  = 2'd0;
    localparam logic [1:0] REQ_CHECK   = 2'd1;
    localparam logic [1:0] REQ_DESTROY = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [OWNER_W-1:0]  owner_id;
        logic [CAP_W-1:0]    cap_set;
        logic [HANDLE_W-1:0] handle_in;
        logic [CAP_W-1:0]    required_caps;
    } req_t;

    typedef struct packed {
        logic                status;
        logic [HANDLE_W-1:0] handle_out;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic cap_eval;
    } ght_cmd_t;

    typedef struct packed {
        logic is_check;
    } ght_stat_t;

endpackage

// ===== rtl/ght_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/ght_datapath.sv =====
// Slot state, free-slot search, handle decode and result registers.
module ght_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  ght_pkg::ght_cmd_t  cmd,
    output ght_pkg::ght_stat_t stat,
    input  ght_pkg::req_t   req_in,
    output ght_pkg::rsp_t   rsp_out
);
    import ght_pkg::*;

    req_t               req_reg;
    logic               used_reg [SLOTS];
    logic [GEN_W-1:0]   gen_reg  [SLOTS];
    logic               dec_ok_reg;
    logic               status_reg;
    logic [HANDLE_W-1:0] handle_reg;

    logic               found;
    logic [SLOT_W-1:0]  free_idx;
    logic [PART_W-1:0]  part;
    logic [GEN_W-1:0]   gen_in;
    logic               range_ok;
    logic [SLOT_W-1:0]  dec_idx;
    logic [SLOT_W-1:0]  rd_idx;
    logic [GEN_W-1:0]   rd_gen;
    logic               rd_used;
    logic [GEN_W-1:0]   gen_inc;
    logic               create_ok;
    logic               decode_ok;
    logic [CAP_W-1:0]   caps_rdata;

    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i] && gen_reg[i] != GEN_MAX)
            begin
                found    = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign part     = req_reg.handle_in[PART_W-1:0];
    assign gen_in   = req_reg.handle_in[HANDLE_W-1:PART_W];
    assign range_ok = (part != '0) && (part <= PART_W'(SLOTS)) && (gen_in != '0);
    assign dec_idx  = SLOT_W'(part - PART_W'(1));
    assign rd_idx   = (req_reg.req_type == REQ_CREATE) ? free_idx : dec_idx;
    assign rd_gen   = gen_reg[rd_idx];
    assign rd_used  = used_reg[rd_idx];
    assign gen_inc  = rd_gen + GEN_W'(1);

    assign create_ok = (req_reg.owner_id != '0) && found;
    assign decode_ok = range_ok && rd_used && (rd_gen == gen_in);

    assign stat.is_check = (req_reg.req_type == REQ_CHECK);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                used_reg[i] <= 1'b0;
                gen_reg[i]  <= '0;
            end
        end
        else if (cmd.exec)
        begin
            case (req_reg.req_type)
                REQ_CREATE:
                begin
                    if (create_ok)
                    begin
                        used_reg[free_idx] <= 1'b1;
                        gen_reg[free_idx]  <= gen_inc;
                    end
                end
                REQ_DESTROY:
                begin
                    if (decode_ok)
                    begin
                        used_reg[dec_idx] <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            dec_ok_reg <= decode_ok;
            status_reg <= STATUS_FAIL;
            handle_reg <= '0;
            case (req_reg.req_type)
                REQ_CREATE:
                begin
                    if (create_ok)
                    begin
                        status_reg <= STATUS_OK;
                        handle_reg <= {gen_inc, PART_W'({1'b0, free_idx} + 1)};
                    end
                end
                REQ_DESTROY:
                begin
                    if (decode_ok)
                    begin
                        status_reg <= STATUS_OK;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.cap_eval)
        begin
            status_reg <= (dec_ok_reg && ((caps_rdata & req_reg.required_caps) != '0))
                          ? STATUS_OK : STATUS_FAIL;
            handle_reg <= '0;
        end
    end

    ght_ram #(
        .WIDTH (CAP_W),
        .DEPTH (SLOTS)
    ) u_caps (
        .clk   (clk),
        .we    (cmd.exec && (req_reg.req_type == REQ_CREATE) && create_ok),
        .waddr (free_idx),
        .wdata (req_reg.cap_set),
        .raddr (rd_idx),
        .rdata (caps_rdata)
    );

    assign rsp_out.status     = status_reg;
    assign rsp_out.handle_out = handle_reg;

endmodule

// ===== rtl/ght_ctrl.sv =====
// Controller: sequences load, execute, capability test and result hand-off.
module ght_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output ght_pkg::ght_cmd_t  cmd,
    input  ght_pkg::ght_stat_t stat
);
    import ght_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CAPS,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   stall_reg;
    logic   valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= S_EXEC;
                        stall_reg <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    if (stat.is_check)
                    begin
                        state_reg <= S_CAPS;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                        valid_reg <= 1'b1;
                    end
                end
                S_CAPS:
                begin
                    state_reg <= S_OUT;
                    valid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (!rsp_stall)
                    begin
                        state_reg <= S_IDLE;
                        valid_reg <= 1'b0;
                        stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    valid_reg <= 1'b0;
                    stall_reg <= 1'b0;
                end
            endcase
        end
    end

    assign req_stall    = stall_reg;
    assign rsp_valid    = valid_reg;
    assign cmd.load     = (state_reg == S_IDLE) && req_valid;
    assign cmd.exec     = (state_reg == S_EXEC);
    assign cmd.cap_eval = (state_reg == S_CAPS);

endmodule

// ===== rtl/generational_handle_table.sv =====
// Generational handle table: top level joining controller and datapath.
// One item is handled at a time: create and destroy step from S_EXEC to
// S_OUT, which raises rsp_valid; check passes through S_CAPS first because its
// capability set comes out of the slot RAM's registered read port. The next
// item is accepted no earlier than the edge after the result is taken. The
// free-slot search is a combinational priority pick over the slot used and
// generation flops.
module generational_handle_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ght_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ght_pkg::rsp_t rsp
);
    import ght_pkg::*;

    ght_cmd_t  cmd;
    ght_stat_t stat;

    ght_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    ght_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .req_in  (req),
        .rsp_out (rsp)
    );

endmodule
